// ===== rtl/core/bayer_demosaic_to_ycbcr422_top_defines.svh =====
// assertion macros used by the checker file
`ifndef BAYER_DEMOSAIC_TO_YCBCR422_TOP_DEFINES_SVH
`define BAYER_DEMOSAIC_TO_YCBCR422_TOP_DEFINES_SVH

// same-cycle implication, checking off while in reset
`define BDM422_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking off while in reset
`define BDM422_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bdm422_pkg.sv =====
// shared types, constants and coefficients of the demosaic and colour converter
package bdm422_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LINES_STORED   = 2;
  localparam int LINE_WORD_W    = LINES_STORED * SAMPLE_W;
  localparam int MAX_WIDTH_DFLT = 2048;

  localparam int CFG_FW_W   = 12;
  localparam int CFG_FH_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 14;

  localparam logic [CFG_FW_W-1:0] FW_RESET = 12'd1920;
  localparam logic [CFG_FH_W-1:0] FH_RESET = 13'd1080;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam int OUT_DEPTH  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // colour conversion, scale 1/1000
  localparam int VAL_W   = 28;
  localparam int PROD_W  = 26;
  localparam int COEF_W  = 10;
  localparam int Y_OFF   = 16000;
  localparam int C_OFF   = 128000;
  // order: y r g b, cb r g b, cr r g b (signs applied in the adders)
  localparam logic [COEF_W-1:0] COEF [9] = '{
    10'd183, 10'd614, 10'd62,
    10'd101, 10'd338, 10'd439,
    10'd439, 10'd399, 10'd40
  };

  // floor(x/5) for x below 2^19 as (x * RECIP5) >> RECIP5_SH
  localparam int GSUM_W    = 19;
  localparam int RECIP5    = 419431;
  localparam int RECIP5_SH = 21;

  // floor(v/1000) for v below SAT_LIMIT as (v * RECIP1000) >> RECIP1000_SH
  localparam int SAT_LIMIT    = 256000;
  localparam int SAT_W        = 18;
  localparam int RECIP1000    = 268436;
  localparam int RECIP1000_SH = 28;

  typedef logic [8:0][SAMPLE_W-1:0] win_t;

  typedef struct packed {
    logic orow_odd;
    logic ocol_odd;
    logic is_cr;
    logic line_end;
    logic frame_end;
  } pix_tag_t;

  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] luma;
    pix_tag_t   tag;
  } pix_out_t;

endpackage

// ===== rtl/core/bdm422_csc.sv =====
// colour interpolation from a 3x3 window and rgb to ycbcr conversion pipeline
module bdm422_csc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  bdm422_pkg::win_t     in_win_i,
  input  bdm422_pkg::pix_tag_t in_tag_i,
  output logic                 out_valid_o,
  output bdm422_pkg::pix_out_t out_pix_o
);
  import bdm422_pkg::*;

  localparam int P5_W    = 2 * GSUM_W;
  localparam int P1000_W = SAT_W + GSUM_W;

  // stage 1: neighbour sums
  logic                v1_q;
  pix_tag_t            t1_q;
  logic [SAMPLE_W-1:0] r1_q, b1_q;
  logic [GSUM_W-1:0]   g1_q;
  logic                div5_q;
  logic [SAMPLE_W-1:0] r1_d, b1_d;
  logic [GSUM_W-1:0]   g1_d;
  logic                div5_d;
  logic [17:0]         sum_x, sum_p, sum_h, sum_v;
  logic [GSUM_W-1:0]   sum_g5;

  // stage 2: green divide by five
  logic                v2_q;
  pix_tag_t            t2_q;
  logic [SAMPLE_W-1:0] r2_q, g2_q, b2_q;
  logic [P5_W-1:0]     g5_prod;

  // stage 3: coefficient products
  logic                            v3_q;
  pix_tag_t                        t3_q;
  logic [8:0][PROD_W-1:0]          prod_q;
  logic [8:0][PROD_W-1:0]          prod_d;

  // stage 4: sums
  logic             v4_q;
  pix_tag_t         t4_q;
  logic [VAL_W-1:0] y_q, c_q;
  logic [VAL_W-1:0] y_d, cb_d, cr_d;

  function automatic logic [7:0] to_byte(input logic [VAL_W-1:0] v);
    logic [P1000_W-1:0] prod;
    prod = P1000_W'(v[SAT_W-1:0]) * P1000_W'(RECIP1000);
    if (v[VAL_W-1]) begin
      return 8'd0;
    end else if (v >= VAL_W'(SAT_LIMIT)) begin
      return 8'hff;
    end else begin
      return prod[RECIP1000_SH+7:RECIP1000_SH];
    end
  endfunction

  always_comb begin
    sum_x  = 18'(in_win_i[0]) + 18'(in_win_i[2]) + 18'(in_win_i[6]) + 18'(in_win_i[8]);
    sum_p  = 18'(in_win_i[1]) + 18'(in_win_i[3]) + 18'(in_win_i[5]) + 18'(in_win_i[7]);
    sum_h  = 18'(in_win_i[3]) + 18'(in_win_i[5]);
    sum_v  = 18'(in_win_i[1]) + 18'(in_win_i[7]);
    sum_g5 = GSUM_W'(sum_x) + GSUM_W'(in_win_i[4]);
    case ({in_tag_i.orow_odd, in_tag_i.ocol_odd})
      2'b00: begin
        // red site
        r1_d   = in_win_i[4];
        g1_d   = GSUM_W'(sum_p[17:2]);
        b1_d   = sum_x[17:2];
        div5_d = 1'b0;
      end
      2'b01: begin
        // green on a red row
        r1_d   = sum_h[16:1];
        g1_d   = sum_g5;
        b1_d   = sum_v[16:1];
        div5_d = 1'b1;
      end
      2'b10: begin
        // green on a blue row
        r1_d   = sum_v[16:1];
        g1_d   = sum_g5;
        b1_d   = sum_h[16:1];
        div5_d = 1'b1;
      end
      default: begin
        // blue site
        r1_d   = sum_x[17:2];
        g1_d   = GSUM_W'(sum_p[17:2]);
        b1_d   = in_win_i[4];
        div5_d = 1'b0;
      end
    endcase
  end

  assign g5_prod = P5_W'(g1_q) * P5_W'(RECIP5);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      case (i % 3)
        0:       prod_d[i] = PROD_W'(r2_q) * PROD_W'(COEF[i]);
        1:       prod_d[i] = PROD_W'(g2_q) * PROD_W'(COEF[i]);
        default: prod_d[i] = PROD_W'(b2_q) * PROD_W'(COEF[i]);
      endcase
    end
  end

  always_comb begin
    y_d  = VAL_W'(Y_OFF) + VAL_W'(prod_q[0]) + VAL_W'(prod_q[1]) + VAL_W'(prod_q[2]);
    cb_d = VAL_W'(C_OFF) - VAL_W'(prod_q[3]) - VAL_W'(prod_q[4]) + VAL_W'(prod_q[5]);
    cr_d = VAL_W'(C_OFF) + VAL_W'(prod_q[6]) - VAL_W'(prod_q[7]) - VAL_W'(prod_q[8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= in_tag_i;
    r1_q   <= r1_d;
    g1_q   <= g1_d;
    b1_q   <= b1_d;
    div5_q <= div5_d;

    t2_q <= t1_q;
    r2_q <= r1_q;
    b2_q <= b1_q;
    g2_q <= div5_q ? g5_prod[RECIP5_SH+SAMPLE_W-1:RECIP5_SH] : g1_q[SAMPLE_W-1:0];

    t3_q   <= t2_q;
    prod_q <= prod_d;

    t4_q <= t3_q;
    y_q  <= y_d;
    c_q  <= t3_q.is_cr ? cr_d : cb_d;
  end

  assign out_valid_o      = v4_q;
  assign out_pix_o.luma   = to_byte(y_q);
  assign out_pix_o.chroma = to_byte(c_q);
  assign out_pix_o.tag    = t4_q;

endmodule

// ===== rtl/core/bayer_demosaic_to_ycbcr422_top.sv =====
// rggb bayer demosaic with rgb to ycbcr 4:2:2 conversion, top level
// a result beat comes from the input beat that completes its window,
//   which is frame_width+1 accepted beats after its own sample
// throughput: one beat per cycle while ready; one line store read and one write per cycle
// s_axis_tready only falls when 8 results are in flight or queued at the output
// reset (async, active low) clears counters, window, queue and config (1920 x 1080);
//   the line store keeps its contents and is only read where it was written
module bayer_demosaic_to_ycbcr422_top #(
  parameter int MAX_WIDTH = bdm422_pkg::MAX_WIDTH_DFLT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bdm422_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] raw_sample
  input  logic                              s_axis_tuser,   // [0] action
  // output beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdm422_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] luma, [15:8] chroma
  output logic [bdm422_pkg::OUT_USER_W-1:0] m_axis_tuser,   // [0] chroma_is_cr, [1] frame_end
  output logic                              m_axis_tlast,   // line_end
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bdm422_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bdm422_pkg::*;

  localparam int CLW   = $clog2(MAX_WIDTH);      // column index bits
  localparam int WW    = $clog2(MAX_WIDTH + 1);  // bits to hold a width
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // config registers
  logic [CFG_FW_W-1:0] fw_q;
  logic [CFG_FH_W-1:0] fh_q;

  // input-side counters
  logic [CLW-1:0]   col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             phase_q, phase_d;

  // stage 0 decode
  logic             s_acc;
  logic [WW-1:0]    w_eff;
  logic [CFG_FH_W-1:0] h_eff;
  logic             wrap, drain, take, have, last, col_zero, line_done;
  logic             row_ge_h, row_ge1, row_ge2;
  logic [CLW-1:0]   col_a;
  logic [ROW_W-1:0] row_a;
  logic [WW-1:0]    col_inc;
  pix_tag_t         tag0;

  // stage 1: line store data back, window update
  logic                   p1_valid_q, p1_have_q, p1_czero_q, p1_rge1_q, p1_rge2_q;
  logic [CLW-1:0]         p1_col_q;
  logic [SAMPLE_W-1:0]    p1_sample_q;
  pix_tag_t               p1_tag_q;
  logic [LINE_WORD_W-1:0] ls_mem [MAX_WIDTH];
  logic [LINE_WORD_W-1:0] ls_rd_q, ls_rd, ls_wdata;
  logic                   fwd_q;
  logic [LINE_WORD_W-1:0] fwd_data_q;
  logic [SAMPLE_W-1:0]    top_s, mid_s;
  win_t                   win_q, win_d, emit_win;

  // stage 2: window handed to the converter
  logic     ev_q;
  win_t     ewin_q;
  pix_tag_t etag_q;

  logic     csc_valid;
  pix_out_t csc_pix;

  // output queue and credits
  pix_out_t         fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [CNT_W-1:0] credit_q, credit_d;
  logic             pop;
  pix_out_t         head;

  // ---------------------------------------------------------------------------
  // stage 0: frame position, decide what the beat does
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (credit_q < CNT_W'(OUT_DEPTH));
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign drain         = s_axis_tuser;

  always_comb begin
    // width clamped to 1..MAX_WIDTH, a zero height acts as one line
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    h_eff = (fh_q == '0) ? CFG_FH_W'(1) : fh_q;

    // column past the width after a width change: wrap first
    wrap     = (WW'(col_q) >= w_eff);
    col_a    = wrap ? '0 : col_q;
    row_a    = wrap ? row_q + ROW_W'(1) : row_q;
    col_zero = (col_a == '0);
    row_ge_h = (row_a >= ROW_W'(h_eff));
    row_ge1  = (row_a != '0);
    row_ge2  = (row_a >= ROW_W'(2));

    // drain beat while samples are due, or sample while draining: dropped
    take = (drain == row_ge_h);
    have = take && (col_zero ? row_ge2 : row_ge1);
    last = take && drain && col_zero && (row_a >= ROW_W'(h_eff) + ROW_W'(1));

    col_inc   = WW'(col_a) + WW'(1);
    line_done = (col_inc >= w_eff);

    // output pixel is one row up and one column back, or the end of the line two rows up
    tag0.orow_odd  = col_zero ? row_a[0] : ~row_a[0];
    tag0.ocol_odd  = col_zero ? ~w_eff[0] : ~col_a[0];
    tag0.is_cr     = ~phase_q;
    tag0.line_end  = col_zero;
    tag0.frame_end = last;

    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    if (s_acc) begin
      col_d = col_a;
      row_d = row_a;
      if (take) begin
        if (last) begin
          col_d = '0;
          row_d = '0;
        end else if (line_done) begin
          col_d = '0;
          row_d = row_a + ROW_W'(1);
        end else begin
          col_d = col_inc[CLW-1:0];
        end
      end
      if (have) begin
        phase_d = last ? 1'b0 : ~phase_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: two lines per entry, old line low, newer line high
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      ls_mem[p1_col_q] <= ls_wdata;
    end
    if (s_acc && take) begin
      ls_rd_q <= ls_mem[col_a];
    end
  end

  always_comb begin
    // a write to the entry being read in the same cycle is forwarded
    ls_rd    = fwd_q ? fwd_data_q : ls_rd_q;
    top_s    = p1_rge2_q ? ls_rd[SAMPLE_W-1:0] : '0;
    mid_s    = p1_rge1_q ? ls_rd[LINE_WORD_W-1:SAMPLE_W] : '0;
    ls_wdata = {p1_sample_q, mid_s};

    for (int r = 0; r < 3; r++) begin
      emit_win[3*r]     = win_q[3*r+1];
      emit_win[3*r + 1] = win_q[3*r+2];
    end
    // line start: the emitted pixel sits at the right frame edge
    emit_win[2] = p1_czero_q ? '0 : top_s;
    emit_win[5] = p1_czero_q ? '0 : mid_s;
    emit_win[8] = p1_czero_q ? '0 : p1_sample_q;

    win_d = win_q;
    if (p1_valid_q) begin
      if (p1_tag_q.frame_end) begin
        win_d = '0;
      end else if (p1_czero_q) begin
        win_d    = '0;
        win_d[2] = top_s;
        win_d[5] = mid_s;
        win_d[8] = p1_sample_q;
      end else begin
        win_d = emit_win;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // colour interpolation and conversion
  // ---------------------------------------------------------------------------
  bdm422_csc u_csc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ev_q),
    .in_win_i    (ewin_q),
    .in_tag_i    (etag_q),
    .out_valid_o (csc_valid),
    .out_pix_o   (csc_pix)
  );

  // ---------------------------------------------------------------------------
  // output queue; credits count results in flight plus queued
  // ---------------------------------------------------------------------------
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {head.chroma, head.luma};
  assign m_axis_tuser  = {head.tag.frame_end, head.tag.is_cr};
  assign m_axis_tlast  = head.tag.line_end;

  always_comb begin
    fifo_cnt_d = fifo_cnt_q + CNT_W'(csc_valid) - CNT_W'(pop);
    credit_d   = credit_q + CNT_W'(s_acc && have) - CNT_W'(pop);
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FW_RESET;
      fh_q       <= FH_RESET;
      col_q      <= '0;
      row_q      <= '0;
      phase_q    <= 1'b0;
      p1_valid_q <= 1'b0;
      p1_have_q  <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
      ev_q       <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[CFG_FW_W-1:0];
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[CFG_FH_W-1:0];
        endcase
      end
      col_q      <= col_d;
      row_q      <= row_d;
      phase_q    <= phase_d;
      p1_valid_q <= s_acc && take;
      p1_have_q  <= s_acc && have;
      fwd_q      <= s_acc && take && p1_valid_q && (col_a == p1_col_q);
      win_q      <= win_d;
      ev_q       <= p1_valid_q && p1_have_q;
      if (csc_valid) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_d;
      credit_q   <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_col_q    <= col_a;
    p1_czero_q  <= col_zero;
    p1_rge1_q   <= row_ge1;
    p1_rge2_q   <= row_ge2;
    p1_sample_q <= drain ? '0 : s_axis_tdata;
    p1_tag_q    <= tag0;
    fwd_data_q  <= ls_wdata;
    ewin_q      <= emit_win;
    etag_q      <= p1_tag_q;
    if (csc_valid) begin
      fifo_q[wr_ptr_q] <= csc_pix;
    end
  end

endmodule

// ===== rtl/core/bdm422_chk.sv =====
// port-level checker for the demosaic top level, with its bind
`include "bayer_demosaic_to_ycbcr422_top_defines.svh"

module bdm422_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bdm422_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [bdm422_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                              m_axis_tlast
);

  // the frame ends on the last pixel of the last line
  `BDM422_ASSERT_IMP(a_fend_is_line_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "frame end beat without line end")

  // a stalled beat stays offered
  `BDM422_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat withdrawn while stalled")

  // and keeps its payload
  `BDM422_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output payload changed while stalled")

  // out of reset the queue is empty and input is open
  `BDM422_ASSERT_IMP(a_reset_state, clk_i, rst_ni, $rose(rst_ni), s_axis_tready && !m_axis_tvalid, "queue not empty after reset")

endmodule

bind bayer_demosaic_to_ycbcr422_top bdm422_chk u_bdm422_chk (.*);
